>>> sv/rdps_pkg.sv
package rdps_pkg;

    localparam int PIXEL_BITS        = 24;
    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int KEEP_BITS         = 5;
    localparam int DRAW_BITS         = 15;
    localparam int REG_BITS          = 64;
    localparam int ADDR_BITS         = 5;
    localparam logic [DRAW_BITS-1:0] DRAW_LIMIT = 15'h2C00;

    typedef enum logic [1:0] {
        REG_CHANNEL_ENABLE = 2'd0,
        REG_SEED_LOW       = 2'd1,
        REG_SEED_HIGH      = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [REG_BITS-1:0] word_a;
        logic [REG_BITS-1:0] word_b;
        logic [REG_BITS-1:0] cache;
    } t_rng_state;

    // one xorshift128+ step, result lands in the cache
    function automatic t_rng_state rng_step(input t_rng_state s);
        logic [REG_BITS-1:0] x;
        logic [REG_BITS-1:0] y;
        t_rng_state          r;
        x = s.word_a;
        y = s.word_b;
        x = x ^ (x << 23);
        x = x ^ (x >> 17);
        x = x ^ y ^ (y >> 26);
        r.word_a = y;
        r.word_b = x;
        r.cache  = x + y;
        return r;
    endfunction

endpackage

>>> sv/random_drift_pixel_smoother.sv
// Random drift pixel smoother. Each beat on the slave stream carries the old pixel
// above and the old pixel to the left (RGB, CHANNEL_BITS per channel); the block
// averages the top five bits of each enabled channel and nudges the result one step
// up or down from a 15-bit xorshift128+ draw (above 0x2C00 moves up), saturating at
// both ends. Disabled channels come out as zero and use no draw. One beat is taken
// per clock while the output is not stalled: the generator update for all three
// channels, up to three chained generator steps, completes in the accept cycle, and
// the averaging and drift fill the output register when it can advance. Seeds and the
// channel enable are to be written over the APB port only while the stream is idle;
// the block does not enforce this. A seed write empties the 64-bit draw cache.
module random_drift_pixel_smoother
    import rdps_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // above_pixel [23:0], left_pixel [47:24]
    input  logic [2*PIXEL_BITS-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_pixel [23:0]
    output logic [PIXEL_BITS-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [REG_BITS-1:0]   pwdata,
    output logic [REG_BITS-1:0]   prdata,
    output logic                  pready
);

    localparam int CH_SHIFT = CHANNEL_BITS - KEEP_BITS;

    logic [2:0]            r_enable;
    logic [REG_BITS-1:0]   r_seed_low;
    logic [REG_BITS-1:0]   r_seed_high;
    t_rng_state            r_rng;
    t_rng_state            n_rng;

    logic                  r1_valid;
    logic [PIXEL_BITS-1:0] r1_above;
    logic [PIXEL_BITS-1:0] r1_left;
    logic [2:0]            r1_en;
    logic [2:0]            r1_up;
    logic [2:0]            n_up;

    logic                  r2_valid;
    logic [PIXEL_BITS-1:0] r2_data;
    logic [2:0]            r2_en;
    logic [PIXEL_BITS-1:0] n_data;

    logic                  cfg_wr;
    t_reg_idx              cfg_idx;
    logic                  advance;
    logic                  accept;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_BITS-1:3]);

    always_comb begin
        unique case (cfg_idx)
            REG_CHANNEL_ENABLE: prdata = REG_BITS'(r_enable);
            REG_SEED_LOW:       prdata = r_seed_low;
            REG_SEED_HIGH:      prdata = r_seed_high;
            default:            prdata = '0;
        endcase
    end

    assign advance       = !r2_valid || m_axis_tready;
    assign s_axis_tready = !r1_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r2_valid;
    assign m_axis_tdata  = r2_data;

    // draws for red, green, blue in that order
    always_comb begin
        t_rng_state st;
        st   = r_rng;
        n_up = '0;
        for (int ch = 2; ch >= 0; ch--) begin
            if (r_enable[ch]) begin
                if (st.cache == '0) begin
                    st = rng_step(st);
                end
                n_up[ch] = st.cache[DRAW_BITS-1:0] > DRAW_LIMIT;
                st.cache = st.cache >> 16;
            end
        end
        n_rng = st;
    end

    always_comb begin
        logic [KEEP_BITS-1:0] a5;
        logic [KEEP_BITS-1:0] b5;
        logic [KEEP_BITS:0]   sum;
        logic [KEEP_BITS-1:0] v5;
        n_data = '0;
        for (int ch = 0; ch < 3; ch++) begin
            a5  = r1_above[ch*CHANNEL_BITS + CHANNEL_BITS-1 -: KEEP_BITS];
            b5  = r1_left[ch*CHANNEL_BITS + CHANNEL_BITS-1 -: KEEP_BITS];
            sum = {1'b0, a5} + {1'b0, b5};
            v5  = sum[KEEP_BITS:1];
            if (r1_up[ch]) begin
                v5 = (v5 >= 5'd30) ? 5'd31 : v5 + 5'd1;
            end else begin
                v5 = (v5 <= 5'd1) ? 5'd0 : v5 - 5'd1;
            end
            if (r1_en[ch]) begin
                n_data[ch*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(v5) << CH_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 3'd7;
            r_seed_low  <= REG_BITS'(1);
            r_seed_high <= '0;
            r_rng       <= '{word_a: REG_BITS'(1), word_b: '0, cache: '0};
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_CHANNEL_ENABLE: r_enable <= pwdata[2:0];
                    REG_SEED_LOW: begin
                        r_seed_low   <= pwdata;
                        r_rng.word_a <= pwdata;
                        r_rng.cache  <= '0;
                    end
                    REG_SEED_HIGH: begin
                        r_seed_high  <= pwdata;
                        r_rng.word_b <= pwdata;
                        r_rng.cache  <= '0;
                    end
                    default: ;
                endcase
            end else if (accept) begin
                r_rng <= n_rng;
            end
            if (s_axis_tready) begin
                r1_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r2_valid <= r1_valid;
            end
        end
        if (accept) begin
            r1_above <= s_axis_tdata[PIXEL_BITS-1:0];
            r1_left  <= s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
            r1_en    <= r_enable;
            r1_up    <= n_up;
        end
        if (advance && r1_valid) begin
            r2_data <= n_data;
            r2_en   <= r1_en;
        end
    end

`ifndef SYNTHESIS
    a_seed_clears_cache: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (cfg_idx == REG_SEED_LOW || cfg_idx == REG_SEED_HIGH))
            |=> (r_rng.cache == '0))
        else $error("seed write left draw cache loaded");

    a_all_disabled_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r2_en == 3'd0) |-> (m_axis_tdata == '0))
        else $error("output nonzero with all channels disabled");

    a_blue_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r2_en[0]) |-> (m_axis_tdata[CHANNEL_BITS-1:0] == '0))
        else $error("disabled blue channel nonzero");

    a_low_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata & PIXEL_BITS'(((1 << CH_SHIFT) - 1) *
            ((1 << (2*CHANNEL_BITS)) + (1 << CHANNEL_BITS) + 1))) == '0))
        else $error("bits below the kept channel bits set");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r1_valid && r2_valid && !m_axis_tready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
